@@ hdl/limb_division_by_two_limb_divisor_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the two-limb divisor division block
// Shared concurrent assertion forms, clocked; one is held off during reset, one is not.
// ----------------------------------------------------------------------------
`ifndef LIMB_DIVISION_BY_TWO_LIMB_DIVISOR_TOP_ASSERT_SVH
`define LIMB_DIVISION_BY_TWO_LIMB_DIVISOR_TOP_ASSERT_SVH

// Property checked on every rising edge while reset is released.
`define LDT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Property checked on every rising edge, reset included.
`define LDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ hdl/ldt_pkg.sv @@
// ----------------------------------------------------------------------------
// ldt_pkg
// Types and constants for the two-limb divisor division block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ldt_pkg;

    // Default limb width.
    localparam int DEF_LIMB_BITS = 64;

    // Configuration register index width and register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR_LOW  = 2'd1;

    // Position inside the current dividend.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TOP  = 2'd1,
        PH_RUN  = 2'd2
    } t_phase;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_OUT  = 2'd2
    } t_state;

endpackage

`default_nettype wire

@@ hdl/limb_division_by_two_limb_divisor_top.sv @@
// ----------------------------------------------------------------------------
// limb_division_by_two_limb_divisor_top
// Divides a streamed multi-limb dividend by a two-limb divisor held in
// configuration registers, one quotient limb per dividend limb past the top one.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_axis    in         tdata: limb; tuser: first; tlast: last
//  m_axis    out        tdata: quotient_limb, rem_high, rem_low; tuser: is_top_flag;
//                       tlast: done_res
//  cfg       in         index 0 divisor_high, index 1 divisor_low
//
//  A body limb runs through the shift-subtract loop, one quotient bit per
//  cycle through one 2*LIMB_BITS subtractor, and then ST_OUT loads the output
//  register, which holds the result as valid. Once the result is taken, the
//  output valid clears and the next limb can be accepted; no limb is taken
//  while a limb is in the loop or its result waits.
//  A second limb loads its top flag result at the accepting edge; a top limb
//  gives a result only when it is also the last.
//  Reset is synchronous, active low, and clears the sequencer, phase,
//  remainder and output valid.
//  A stalled result holds the output register; no new limb is taken until
//  it is transferred. Configuration writes are always taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module limb_division_by_two_limb_divisor_top #(
    parameter int LIMB_BITS = ldt_pkg::DEF_LIMB_BITS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // Input stream
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata from bit 0 up: limb, zero fill
    input  wire  [((LIMB_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: first
    input  wire                           s_axis_tuser,
    input  wire                           s_axis_tlast,
    // Result stream
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // tdata from bit 0 up: quotient_limb, rem_high, rem_low, zero fill
    output logic [((3*LIMB_BITS+7)/8)*8-1:0] m_axis_tdata,
    // tuser: is_top_flag
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,
    // Configuration write channel
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [ldt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [LIMB_BITS-1:0]          i_cfg_data
);

    import ldt_pkg::*;

    localparam int OUT_W = ((3*LIMB_BITS+7)/8)*8;
    localparam int CNT_W = (LIMB_BITS > 1) ? $clog2(LIMB_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LIMB_BITS - 1);

    // Registers
    logic [LIMB_BITS-1:0] r_div_hi;
    logic [LIMB_BITS-1:0] r_div_lo;
    t_state               r_state, n_state;
    t_phase               r_phase, n_phase;
    logic [LIMB_BITS-1:0] r_rem_hi, n_rem_hi;
    logic [LIMB_BITS-1:0] r_rem_lo, n_rem_lo;
    logic [LIMB_BITS-1:0] r_limb, n_limb;
    logic [LIMB_BITS-1:0] r_quot, n_quot;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_last, n_last;
    logic                 r_out_valid, n_out_valid;
    logic [LIMB_BITS-1:0] r_out_q, n_out_q;
    logic [LIMB_BITS-1:0] r_out_rh, n_out_rh;
    logic [LIMB_BITS-1:0] r_out_rl, n_out_rl;
    logic                 r_out_top, n_out_top;
    logic                 r_out_done, n_out_done;

    // Combinational signals
    logic                   w_in_xfer;
    logic                   w_out_xfer;
    logic [LIMB_BITS-1:0]   w_in_limb;
    logic [LIMB_BITS-1:0]   w_op_hi;
    logic [LIMB_BITS-1:0]   w_op_lo;
    logic                   w_carry;
    logic [2*LIMB_BITS:0]   w_diff;
    logic                   w_ge;
    logic                   w_take;
    logic [LIMB_BITS-1:0]   w_res_hi;
    logic [LIMB_BITS-1:0]   w_res_lo;

    // Handshakes
    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer    = r_out_valid && m_axis_tready;
    assign w_in_limb     = s_axis_tdata[LIMB_BITS-1:0];
    assign o_cfg_ready   = 1'b1;

    // Output ports
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_rl, r_out_rh, r_out_q});
    assign m_axis_tuser  = r_out_top;
    assign m_axis_tlast  = r_out_done;

    // Shared subtractor operands: the shifted remainder during the loop,
    // the top two dividend limbs for the top compare.
    always_comb begin
        if (r_state == ST_DIV) begin
            w_op_hi = {r_rem_hi[LIMB_BITS-2:0], r_rem_lo[LIMB_BITS-1]};
            w_op_lo = {r_rem_lo[LIMB_BITS-2:0], r_limb[LIMB_BITS-1]};
            w_carry = r_rem_hi[LIMB_BITS-1];
        end else begin
            w_op_hi = r_rem_lo;
            w_op_lo = w_in_limb;
            w_carry = 1'b0;
        end
    end

    // Compare and subtract in one wide subtraction, wrapping on borrow.
    assign w_diff   = {1'b0, w_op_hi, w_op_lo} - {1'b0, r_div_hi, r_div_lo};
    assign w_ge     = !w_diff[2*LIMB_BITS];
    assign w_take   = w_carry || w_ge;
    assign w_res_hi = w_take ? w_diff[2*LIMB_BITS-1:LIMB_BITS] : w_op_hi;
    assign w_res_lo = w_take ? w_diff[LIMB_BITS-1:0] : w_op_lo;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && !s_axis_tuser && (r_phase == PH_RUN)) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        n_phase     = r_phase;
        n_rem_hi    = r_rem_hi;
        n_rem_lo    = r_rem_lo;
        n_limb      = r_limb;
        n_quot      = r_quot;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_out_valid = r_out_valid && !w_out_xfer;
        n_out_q     = r_out_q;
        n_out_rh    = r_out_rh;
        n_out_rl    = r_out_rl;
        n_out_top   = r_out_top;
        n_out_done  = r_out_done;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (s_axis_tuser) begin
                        // Top limb of a new dividend.
                        n_rem_hi = '0;
                        n_rem_lo = w_in_limb;
                        if (s_axis_tlast) begin
                            n_phase     = PH_IDLE;
                            n_out_valid = 1'b1;
                            n_out_q     = '0;
                            n_out_top   = 1'b1;
                            n_out_done  = 1'b1;
                            n_out_rh    = '0;
                            n_out_rl    = w_in_limb;
                        end else begin
                            n_phase = PH_TOP;
                        end
                    end else if (r_phase == PH_TOP) begin
                        // Second limb: top quotient flag.
                        n_rem_hi    = w_res_hi;
                        n_rem_lo    = w_res_lo;
                        n_out_valid = 1'b1;
                        n_out_q     = LIMB_BITS'(w_ge);
                        n_out_top   = 1'b1;
                        n_out_done  = s_axis_tlast;
                        n_out_rh    = s_axis_tlast ? w_res_hi : '0;
                        n_out_rl    = s_axis_tlast ? w_res_lo : '0;
                        n_phase     = s_axis_tlast ? PH_IDLE : PH_RUN;
                    end else if (r_phase == PH_RUN) begin
                        // Body limb: start the shift-subtract loop.
                        n_limb = w_in_limb;
                        n_quot = '0;
                        n_cnt  = CNT_LAST;
                        n_last = s_axis_tlast;
                    end
                end
            end
            ST_DIV: begin
                // One quotient bit per cycle.
                n_rem_hi = w_res_hi;
                n_rem_lo = w_res_lo;
                n_limb   = {r_limb[LIMB_BITS-2:0], 1'b0};
                n_quot   = {r_quot[LIMB_BITS-2:0], w_take};
                n_cnt    = r_cnt - CNT_W'(1);
            end
            ST_OUT: begin
                n_out_valid = 1'b1;
                n_out_q     = r_quot;
                n_out_top   = 1'b0;
                n_out_done  = r_last;
                n_out_rh    = r_last ? r_rem_hi : '0;
                n_out_rl    = r_last ? r_rem_lo : '0;
                if (r_last) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
            r_rem_hi    <= '0;
            r_rem_lo    <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_rem_hi    <= n_rem_hi;
            r_rem_lo    <= n_rem_lo;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_limb     <= n_limb;
        r_quot     <= n_quot;
        r_cnt      <= n_cnt;
        r_last     <= n_last;
        r_out_q    <= n_out_q;
        r_out_rh   <= n_out_rh;
        r_out_rl   <= n_out_rl;
        r_out_top  <= n_out_top;
        r_out_done <= n_out_done;
    end

    // Divisor registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_hi <= {1'b1, {(LIMB_BITS-1){1'b0}}};
            r_div_lo <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DIVISOR_HIGH: r_div_hi <= i_cfg_data;
                CFG_DIVISOR_LOW:  r_div_lo <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Assertions
`include "limb_division_by_two_limb_divisor_top_assert.svh"

    `LDT_ASSERT(a_no_accept_busy, i_clk, i_rst_n,
        (r_state != ST_IDLE) |-> !s_axis_tready,
        "limb accepted while dividing")
    `LDT_ASSERT(a_loop_ends_in_result, i_clk, i_rst_n,
        (r_state == ST_DIV && r_cnt == '0) |=> ##1 r_out_valid,
        "division loop ended without a result")
    `LDT_ASSERT(a_top_flag_bit, i_clk, i_rst_n,
        (r_out_valid && r_out_top) |-> (r_out_q[LIMB_BITS-1:1] == '0),
        "top quotient flag wider than one bit")
    `LDT_ASSERT(a_done_closes, i_clk, i_rst_n,
        (r_out_valid && r_out_done) |-> (r_phase == PH_IDLE),
        "final result while dividend still open")

endmodule

`default_nettype wire
